FILE: src/assert_macros.svh
// Assertion macros shared by the page bitmap allocator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba assertion failed");

`endif

FILE: src/pba_pkg.sv
// Package for the page bitmap allocator: defaults, request and status codes,
// and the control/result structs of the bit operation unit. No dependencies.
package pba_pkg;

  localparam int unsigned NUM_PAGES_DEF  = 32768;
  localparam int unsigned PAGE_SHIFT_DEF = 12;
  localparam int unsigned WORD_W         = 8;
  localparam logic [15:0] TOTAL_PAGES_RST = 16'd32768;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_RESERVE = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic       find;     // search for the lowest clear bit and set it
    logic       set;      // mark mode: 1 sets the bit, 0 clears it
    logic [2:0] bit_idx;  // mark mode: bit in the word
  } pba_bitop_ctl_t;

  typedef struct packed {
    logic              hit;       // found a clear bit / bit changed state
    logic [2:0]        pos;       // position of the lowest clear bit
    logic [WORD_W-1:0] word_new;  // word to write back
  } pba_bitop_res_t;

endpackage

FILE: src/pba_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module pba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/pba_bitop.sv
// Shared bit operation unit: lowest-clear-bit search or single-bit mark on
// one bitmap word. Depends on pba_pkg.
module pba_bitop (
  input  pba_pkg::pba_bitop_ctl_t          ctl,
  input  logic [pba_pkg::WORD_W-1:0]       word,
  output pba_pkg::pba_bitop_res_t          res
);

  logic [pba_pkg::WORD_W-1:0] mask;
  logic [2:0]                 zpos;
  logic                       any_zero;
  logic [2:0]                 sel;

  always_comb begin
    zpos     = 3'd0;
    any_zero = 1'b0;
    for (int i = pba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        zpos     = 3'(i);
        any_zero = 1'b1;
      end
    end
    sel  = ctl.find ? zpos : ctl.bit_idx;
    mask = pba_pkg::WORD_W'(1) << sel;
    res.pos = zpos;
    if (ctl.find) begin
      res.hit      = any_zero;
      res.word_new = word | mask;
    end else if (ctl.set) begin
      res.hit      = !word[sel];
      res.word_new = word | mask;
    end else begin
      res.hit      = word[sel];
      res.word_new = word & ~mask;
    end
  end

endmodule

FILE: src/page_bitmap_allocator_top.sv
// Page bitmap allocator: first-fit page frame allocator over a used-bit map.
// Depends on pba_pkg, pba_ram, pba_bitop and assert_macros.svh.
//
// Channels: in_* takes one request (in_tuser = request kind, in_tdata = byte
// address); out_* returns one result per request (out_tuser = status,
// out_tdata = allocated address, used count, free count). cfg_* writes the
// installed page count used for the free count; it is taken at any time but
// is meant to change only while no request is in flight.
// Sequence: free, release and reserve pass through S_READ, S_EVAL and S_RESP
// after the item is taken; an out-of-range page or a release of page zero
// goes straight to S_RESP. Allocate reads one bitmap byte per S_READ/S_EVAL
// pass, starting at a hint that points at the lowest byte that may hold a
// clear bit; with no free page known it goes straight to S_RESP. The bitmap
// RAM port and the single bit unit set this per-byte sequence.
// One item is handled at a time; in_tready is low from acceptance until the
// result is taken, so a stalled receiver holds the block with out_tvalid up.
// Reset: the bitmap RAM is filled with ones, one byte per cycle, over all
// ceil(NUM_PAGES / 8) bytes (4096 by default); in_tready stays low meanwhile.
`include "assert_macros.svh"

module page_bitmap_allocator_top #(
  parameter int unsigned NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = pba_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] page_addr
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] alloc_addr, [47:32] used_count, [63:48] free_count
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] installed page count
);

  localparam int unsigned WORDS = (NUM_PAGES + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned CW    = $clog2(NUM_PAGES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW:0]   hint_r, hint_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [15:0]   total_r;
  logic [1:0]    kind_r, kind_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   alloc_r, alloc_nxt;

  logic                         ram_we;
  logic [pba_pkg::WORD_W-1:0]   ram_wdata;
  logic [pba_pkg::WORD_W-1:0]   ram_rdata;
  logic                         ram_re;
  pba_pkg::pba_bitop_ctl_t      op_ctl;
  pba_pkg::pba_bitop_res_t      op_res;

  logic          cnt_en, cnt_dec;
  logic [CW-1:0] cnt_sum;
  logic [31:0]   page32;
  logic          in_range;
  logic [63:0]   alloc_wide;
  logic [31:0]   used32, total32, diff32;
  logic [15:0]   used_out, free_out;

  pba_ram #(
    .WIDTH (pba_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign op_ctl.find    = (kind_r == pba_pkg::REQ_ALLOC);
  assign op_ctl.set     = (kind_r == pba_pkg::REQ_RESERVE);
  assign op_ctl.bit_idx = bit_r;

  pba_bitop u_bitop (
    .ctl  (op_ctl),
    .word (ram_rdata),
    .res  (op_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);
  assign cfg_ready  = 1'b1;
  assign ram_re     = (state_r == S_READ);

  assign page32     = in_tdata >> PAGE_SHIFT;
  assign in_range   = page32 < 32'(NUM_PAGES);
  assign alloc_wide = 64'({addr_r, op_res.pos}) << PAGE_SHIFT;
  assign cnt_sum    = used_r + (cnt_dec ? {CW{1'b1}} : CW'(1));

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    hint_nxt   = hint_r;
    used_nxt   = used_r;
    kind_nxt   = kind_r;
    bit_nxt    = bit_r;
    status_nxt = status_r;
    alloc_nxt  = alloc_r;
    ram_we     = 1'b0;
    ram_wdata  = op_res.word_new;
    cnt_en     = 1'b0;
    cnt_dec    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        addr_nxt  = addr_r + AW'(1);
        if (addr_r == AW'(WORDS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          bit_nxt   = page32[2:0];
          alloc_nxt = '0;
          if (in_tuser == pba_pkg::REQ_ALLOC) begin
            addr_nxt = hint_r[AW-1:0];
            if (hint_r == (AW+1)'(WORDS)) begin
              status_nxt = pba_pkg::ST_NOFREE;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_READ;
            end
          end else begin
            addr_nxt = page32[3 +: AW];
            if (!in_range || (in_tuser == pba_pkg::REQ_RELEASE && page32 == 32'd0)) begin
              status_nxt = pba_pkg::ST_IGNORED;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (op_res.hit) begin
          ram_we     = 1'b1;
          cnt_en     = 1'b1;
          cnt_dec    = (kind_r == pba_pkg::REQ_FREE) || (kind_r == pba_pkg::REQ_RELEASE);
          used_nxt   = cnt_sum;
          status_nxt = pba_pkg::ST_DONE;
          state_nxt  = S_RESP;
          if (op_ctl.find) begin
            hint_nxt  = {1'b0, addr_r};
            alloc_nxt = alloc_wide[31:0];
          end else if (cnt_dec && ({1'b0, addr_r} < hint_r)) begin
            hint_nxt = {1'b0, addr_r};
          end
        end else if (op_ctl.find) begin
          if (addr_r == AW'(WORDS - 1)) begin
            hint_nxt   = (AW+1)'(WORDS);
            status_nxt = pba_pkg::ST_NOFREE;
            state_nxt  = S_RESP;
          end else begin
            addr_nxt  = addr_r + AW'(1);
            state_nxt = S_READ;
          end
        end else begin
          status_nxt = pba_pkg::ST_IGNORED;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      hint_r  <= (AW+1)'(WORDS);
      used_r  <= CW'(NUM_PAGES);
      total_r <= pba_pkg::TOTAL_PAGES_RST;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      hint_r  <= hint_nxt;
      used_r  <= used_nxt;
      if (cfg_valid && cfg_ready) begin
        total_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    bit_r    <= bit_nxt;
    status_r <= status_nxt;
    alloc_r  <= alloc_nxt;
  end

  assign used32   = 32'(used_r);
  assign total32  = 32'(total_r);
  assign diff32   = total32 - used32;
  assign used_out = (used32 > 32'h0000_FFFF) ? 16'hFFFF : used32[15:0];
  assign free_out = (total32 > used32) ? diff32[15:0] : 16'd0;

  assign out_tuser = status_r;
  assign out_tdata = {free_out, used_out, alloc_r};

  `PBA_ASSERT_NOW(a_one_item, clk, rst_n, in_tready, !out_tvalid)
  `PBA_ASSERT_NOW(a_used_bound, clk, rst_n, 1'b1, used_r <= CW'(NUM_PAGES))
  `PBA_ASSERT_NOW(a_nofree_hint, clk, rst_n,
                  out_tvalid && (out_tuser == pba_pkg::ST_NOFREE),
                  hint_r == (AW+1)'(WORDS))
  `PBA_ASSERT_NEXT(a_count_step, clk, rst_n, cnt_en,
                   (used_r == $past(used_r) + CW'(1)) || (used_r == $past(used_r) - CW'(1)))

endmodule

FILE: tb/page_bitmap_allocator_top_tb.sv
`timescale 1ns / 1ps
// Testbench for page_bitmap_allocator_top: directed and random page requests,
// checked item by item against an in-bench first-fit bitmap predictor.
// Depends on pba_pkg and the allocator RTL.
module page_bitmap_allocator_top_tb;

  localparam int unsigned LOW_POOL      = 512;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 130;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_addr;
    logic [15:0] used_count;
    logic [15:0] free_count;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] page_addr
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] alloc_addr, [47:32] used_count, [63:48] free_count
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;   // [15:0] installed page count

  page_req_t    pending_reqs[$];
  page_result_t expected_results[$];
  int unsigned  issued_items = 0;
  int unsigned  accepted_items = 0;
  int unsigned  error_count = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  bit           quiet_tail = 1'b0;

  // predictor state
  bit           page_used [pba_pkg::NUM_PAGES_DEF];
  int unsigned  busy_pages;
  int unsigned  search_from;
  logic [15:0]  installed_pages;

  page_bitmap_allocator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  function automatic page_result_t predict_request(input page_req_t r);
    page_result_t res;
    int unsigned  pg;
    pg = r.addr >> pba_pkg::PAGE_SHIFT_DEF;
    res.status = pba_pkg::ST_IGNORED;
    res.alloc_addr = '0;
    case (r.kind)
      pba_pkg::REQ_ALLOC: begin
        res.status = pba_pkg::ST_NOFREE;
        while (search_from < pba_pkg::NUM_PAGES_DEF && page_used[search_from]) search_from++;
        if (search_from < pba_pkg::NUM_PAGES_DEF) begin
          page_used[search_from] = 1'b1;
          busy_pages++;
          res.alloc_addr = search_from << pba_pkg::PAGE_SHIFT_DEF;
          res.status = pba_pkg::ST_DONE;
          search_from++;
        end
      end
      pba_pkg::REQ_FREE, pba_pkg::REQ_RELEASE: begin
        if (pg < pba_pkg::NUM_PAGES_DEF && page_used[pg] &&
            !(r.kind == pba_pkg::REQ_RELEASE && pg == 0)) begin
          page_used[pg] = 1'b0;
          busy_pages--;
          res.status = pba_pkg::ST_DONE;
          if (pg < search_from) search_from = pg;
        end
      end
      default: begin
        if (pg < pba_pkg::NUM_PAGES_DEF && !page_used[pg]) begin
          page_used[pg] = 1'b1;
          busy_pages++;
          res.status = pba_pkg::ST_DONE;
        end
      end
    endcase
    res.used_count = busy_pages[15:0];
    res.free_count = (installed_pages > busy_pages) ? installed_pages - busy_pages[15:0] : '0;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin : req_driver
    page_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.kind;
        in_tdata <= nxt.addr;
        if (!quiet_tail && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) recv_stall <= $urandom_range(1, 14);
    end
  end

  // monitor and checker
  always @(posedge clk) begin : result_monitor
    page_req_t    req;
    page_result_t want;
    if (!rst_n) begin
      foreach (page_used[p]) page_used[p] = 1'b1;
      busy_pages = pba_pkg::NUM_PAGES_DEF;
      search_from = pba_pkg::NUM_PAGES_DEF;
      installed_pages = pba_pkg::TOTAL_PAGES_RST;
    end else begin
      if (cfg_valid && cfg_ready) installed_pages = cfg_data;
      if (in_tvalid && in_tready) begin
        req.kind = in_tuser;
        req.addr = in_tdata;
        expected_results.push_back(predict_request(req));
        accepted_items++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
          if (out_tdata[31:0] !== want.alloc_addr)
            flag_mismatch($sformatf("alloc_addr %h, want %h", out_tdata[31:0],
                                    want.alloc_addr));
          if (out_tdata[47:32] !== want.used_count)
            flag_mismatch($sformatf("used_count %0d, want %0d", out_tdata[47:32],
                                    want.used_count));
          if (out_tdata[63:48] !== want.free_count)
            flag_mismatch($sformatf("free_count %0d, want %0d", out_tdata[63:48],
                                    want.free_count));
        end
      end
    end
  end

  task automatic queue_req(input logic [1:0] kind, input logic [31:0] addr);
    page_req_t r;
    r.kind = kind;
    r.addr = addr;
    pending_reqs.push_back(r);
    issued_items++;
  endtask

  function automatic logic [31:0] low_addr(input int unsigned pg);
    return (pg << pba_pkg::PAGE_SHIFT_DEF) |
           $urandom_range(0, (1 << pba_pkg::PAGE_SHIFT_DEF) - 1);
  endfunction

  task automatic wait_idle();
    while (accepted_items != issued_items || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_total_pages(input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // boot map walks, alloc/free churn over a low page pool, and wild addresses
  task automatic queue_mixed_traffic(input int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned start;
    int unsigned len;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        start = $urandom_range(1, LOW_POOL - 1);
        len = $urandom_range(1, 40);
        for (int unsigned p = start; p < start + len && p < LOW_POOL; p++)
          queue_req(pba_pkg::REQ_RELEASE, low_addr(p));
        made += len;
      end else begin
        if (pick < 45) begin
          queue_req(pba_pkg::REQ_ALLOC, $urandom());
        end else if (pick < 66) begin
          queue_req(pba_pkg::REQ_FREE, low_addr($urandom_range(0, LOW_POOL - 1)));
        end else if (pick < 78) begin
          queue_req(pba_pkg::REQ_RESERVE, low_addr($urandom_range(0, LOW_POOL - 1)));
        end else if (pick < 90) begin
          queue_req(pba_pkg::REQ_RELEASE, low_addr($urandom_range(0, LOW_POOL - 1)));
        end else begin
          queue_req(2'($urandom_range(0, 3)), $urandom());
        end
        made++;
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] phase_totals [PHASES];
    phase_totals[0] = 16'd0;
    phase_totals[1] = 16'hFFFF;
    phase_totals[2] = 16'h5555;
    phase_totals[3] = 16'hAAAA;
    phase_totals[4] = 16'($urandom_range(0, 65535));
    phase_totals[5] = 16'd1;
    phase_totals[6] = 16'($urandom_range(0, 65535));
    phase_totals[7] = 16'd32768;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: everything starts used, reset value of the installed count
    queue_req(pba_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
    queue_req(pba_pkg::REQ_FREE, 32'h0000_0000);
    queue_req(pba_pkg::REQ_RELEASE, 32'h0000_0FFF);
    queue_req(pba_pkg::REQ_ALLOC, 32'h0000_0000);
    queue_req(pba_pkg::REQ_RELEASE, 32'h0000_1ABC);
    queue_req(pba_pkg::REQ_RELEASE, 32'h0000_1000);
    queue_req(pba_pkg::REQ_FREE, 32'h0000_1FFF);
    queue_req(pba_pkg::REQ_RESERVE, 32'h0000_1001);
    queue_req(pba_pkg::REQ_RESERVE, 32'h0000_1000);
    queue_req(pba_pkg::REQ_RELEASE, 32'h07FF_F000);
    queue_req(pba_pkg::REQ_RELEASE, 32'h0800_0000);
    queue_req(pba_pkg::REQ_FREE, 32'hFFFF_FFFF);
    queue_req(pba_pkg::REQ_RESERVE, 32'hFFFF_FFFF);
    queue_req(pba_pkg::REQ_ALLOC, 32'h5555_5555);
    queue_req(pba_pkg::REQ_ALLOC, 32'hAAAA_AAAA);
    queue_req(pba_pkg::REQ_FREE, 32'h07FF_FFFF);
    queue_req(pba_pkg::REQ_RESERVE, 32'h07FF_F123);
    queue_req(pba_pkg::REQ_RELEASE, 32'h0000_2000);
    queue_req(pba_pkg::REQ_RELEASE, 32'h0000_3555);
    queue_req(pba_pkg::REQ_ALLOC, 32'h0000_0000);
    queue_req(pba_pkg::REQ_ALLOC, 32'h0000_0000);
    queue_req(pba_pkg::REQ_ALLOC, 32'h0000_0000);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) quiet_tail = 1'b1;
      set_total_pages(phase_totals[ph]);
      queue_mixed_traffic(PHASE_ITEMS);
      wait_idle();
      // run the map dry so no-free-page answers show up
      if (ph % 3 == 1) begin
        repeat (pba_pkg::NUM_PAGES_DEF - busy_pages + 2)
          queue_req(pba_pkg::REQ_ALLOC, $urandom());
        wait_idle();
      end
    end

    if (expected_results.size() != 0) flag_mismatch("results still expected at end");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #100000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
